// ----- sv/wlrs_pkg.sv -----
// ----------------------------------------------------------------------------
// wlrs_pkg: shared types and constants of the wear leveled record store
// Transaction structs, slot header layout, status codes and sequencer states.
// ----------------------------------------------------------------------------
package wlrs_pkg;

  localparam int NUM_SLOTS_DEF      = 80;
  localparam int WORDS_PER_SLOT_DEF = 62;

  localparam int SLOT_W = 7;
  localparam int DATA_W = 16;
  localparam int FILL_W = 6;

  localparam logic [DATA_W-1:0] ERASED_WORD = 16'hFFFF;

  typedef enum logic [1:0] {
    SLOT_FREE    = 2'd0,
    SLOT_VALID   = 2'd1,
    SLOT_INVALID = 2'd2
  } slot_state_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_LEN_ERR  = 2'd1,
    ST_NO_VALID = 2'd2,
    ST_IGNORED  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RSCAN,
    S_RWORD,
    S_WSCAN,
    S_ERASE,
    S_OPEN
  } fsm_t;

  typedef struct packed {
    logic              req_type;
    logic              first;
    logic [7:0]        byte_count;
    logic [5:0]        word_index;
    logic [DATA_W-1:0] data;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] read_data;
    logic              erased_all;
  } rsp_t;

  typedef struct packed {
    slot_state_t       st;
    logic [FILL_W-1:0] fill;
  } hdr_t;

endpackage

// ----- sv/wear_leveled_record_store.sv -----
// ----------------------------------------------------------------------------
// wear_leveled_record_store: wear leveled record store over fixed slots
// Slot headers and halfwords live in two RAMs walked by a small sequencer.
// ----------------------------------------------------------------------------
// Usage. A transaction is accepted on a rising edge with start high and busy
// low; in_req carries the request. Every transaction yields exactly one
// result on out_rsp, shown for one cycle with out_valid high. The receiver
// cannot stall, so a result is simply registered and presented once.
//
// Sequencing. A write that continues an open record, a rejected length and an
// ignored write finish in the accept cycle: the result appears on the next
// cycle and busy stays low. A read walks the slot headers one per cycle
// through the header RAM read port up to the first valid one, then fetches
// the stored halfword from the halfword RAM when one is needed; when no
// slot is valid it walks every header. An allocation scans up to the first
// free slot; when no slot is free it adds an erase sweep of every header.
// The header RAM read port paces these walks.
//
// Reset. After rst_n the block runs a clearing pass that marks every slot
// header free and empty; busy is high during that pass.
// Halfword storage is not cleared, since only halfwords below a slot's fill
// count are ever read.
// ----------------------------------------------------------------------------
module wear_leveled_record_store #(
  parameter int NUM_SLOTS      = wlrs_pkg::NUM_SLOTS_DEF,
  parameter int WORDS_PER_SLOT = wlrs_pkg::WORDS_PER_SLOT_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  wlrs_pkg::req_t in_req,
  output logic           out_valid,
  output wlrs_pkg::rsp_t out_rsp
);

  import wlrs_pkg::*;

  localparam int SW    = $clog2(NUM_SLOTS);
  localparam int WDEP  = NUM_SLOTS * WORDS_PER_SLOT;
  localparam int AW    = $clog2(WDEP);
  localparam int HDR_W = $bits(hdr_t);

  localparam logic [SW-1:0]     LAST_SLOT = SW'(NUM_SLOTS - 1);
  localparam logic [AW-1:0]     SLOT_STEP = AW'(WORDS_PER_SLOT);
  localparam logic [FILL_W-1:0] WPS       = FILL_W'(WORDS_PER_SLOT);
  localparam logic [7:0]        LEN_MAX   = 8'(2 * WORDS_PER_SLOT);

  fsm_t              state_r, state_nxt;
  logic [SW-1:0]     idx_r, idx_nxt;
  logic [AW-1:0]     base_r, base_nxt;
  req_t              req_r, req_nxt;
  logic [SW-1:0]     open_slot_r, open_slot_nxt;
  logic [AW-1:0]     open_base_r, open_base_nxt;
  logic [FILL_W-1:0] open_pos_r, open_pos_nxt;
  logic [FILL_W-1:0] open_len_r, open_len_nxt;
  logic              rec_open_r, rec_open_nxt;
  logic              erased_r, erased_nxt;
  logic              out_valid_r, out_valid_nxt;
  rsp_t              out_rsp_r, out_rsp_nxt;

  // RAM ports.
  logic              hdr_we;
  logic [SW-1:0]     hdr_waddr, hdr_raddr;
  hdr_t              hdr_wdata;
  logic [HDR_W-1:0]  hdr_rdata;
  hdr_t              hdr_rd;
  logic              wrd_we;
  logic [AW-1:0]     wrd_waddr, wrd_raddr;
  logic [DATA_W-1:0] wrd_wdata, wrd_rdata;

  // Shared store of one halfword into the open record.
  logic              do_store;
  logic [FILL_W-1:0] st_pos;
  logic [FILL_W-1:0] st_pos_inc;
  logic [DATA_W-1:0] store_data;
  logic              last_slot;

  assign hdr_rd     = hdr_t'(hdr_rdata);
  assign last_slot  = (idx_r == LAST_SLOT);
  assign st_pos_inc = st_pos + 1'b1;

  wlrs_ram #(.WIDTH(HDR_W), .DEPTH(NUM_SLOTS)) u_hdr_ram (
    .clk   (clk),
    .we    (hdr_we),
    .waddr (hdr_waddr),
    .wdata (hdr_wdata),
    .raddr (hdr_raddr),
    .rdata (hdr_rdata)
  );

  wlrs_ram #(.WIDTH(DATA_W), .DEPTH(WDEP)) u_word_ram (
    .clk   (clk),
    .we    (wrd_we),
    .waddr (wrd_waddr),
    .wdata (wrd_wdata),
    .raddr (wrd_raddr),
    .rdata (wrd_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      open_slot_r <= '0;
      open_pos_r  <= '0;
      open_len_r  <= '0;
      rec_open_r  <= 1'b0;
      erased_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      open_slot_r <= open_slot_nxt;
      open_pos_r  <= open_pos_nxt;
      open_len_r  <= open_len_nxt;
      rec_open_r  <= rec_open_nxt;
      erased_r    <= erased_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers carry no reset; they are loaded before use.
  always_ff @(posedge clk) begin
    base_r      <= base_nxt;
    req_r       <= req_nxt;
    open_base_r <= open_base_nxt;
    out_rsp_r   <= out_rsp_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    base_nxt      = base_r;
    req_nxt       = req_r;
    open_slot_nxt = open_slot_r;
    open_base_nxt = open_base_r;
    open_pos_nxt  = open_pos_r;
    open_len_nxt  = open_len_r;
    rec_open_nxt  = rec_open_r;
    erased_nxt    = erased_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    hdr_we        = 1'b0;
    hdr_waddr     = idx_r;
    hdr_wdata     = hdr_t'{st: SLOT_FREE, fill: '0};
    hdr_raddr     = idx_r + 1'b1;
    wrd_we        = 1'b0;
    wrd_waddr     = open_base_r + AW'(open_pos_r);
    wrd_wdata     = req_r.data;
    wrd_raddr     = base_r + AW'(req_r.word_index);
    do_store      = 1'b0;
    st_pos        = open_pos_r;
    store_data    = req_r.data;

    unique case (state_r)
      S_CLEAR: begin
        hdr_we = 1'b1;
        if (last_slot) begin
          state_nxt = S_IDLE;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_IDLE: begin
        hdr_raddr = '0;
        if (start) begin
          req_nxt  = in_req;
          idx_nxt  = '0;
          base_nxt = '0;
          if (!in_req.req_type) begin
            state_nxt = S_RSCAN;
          end else if (in_req.first) begin
            if (in_req.byte_count > LEN_MAX) begin
              // Rejected length closes any open record and touches no slot.
              rec_open_nxt  = 1'b0;
              out_valid_nxt = 1'b1;
              out_rsp_nxt   = rsp_t'{ST_LEN_ERR, '0, '0, 1'b0};
            end else begin
              state_nxt = S_WSCAN;
            end
          end else if (!rec_open_r) begin
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = rsp_t'{ST_IGNORED, '0, '0, 1'b0};
          end else begin
            do_store      = 1'b1;
            store_data    = in_req.data;
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = rsp_t'{ST_OK, SLOT_W'(open_slot_r), '0, 1'b0};
          end
        end
      end

      S_RSCAN: begin
        unique case (hdr_rd.st)
          SLOT_VALID: begin
            if (req_r.word_index < WPS && req_r.word_index < hdr_rd.fill) begin
              state_nxt = S_RWORD;
            end else begin
              state_nxt     = S_IDLE;
              out_valid_nxt = 1'b1;
              out_rsp_nxt   = rsp_t'{ST_OK, SLOT_W'(idx_r), ERASED_WORD, 1'b0};
            end
          end
          default: begin
            if (last_slot) begin
              state_nxt     = S_IDLE;
              out_valid_nxt = 1'b1;
              out_rsp_nxt   = rsp_t'{ST_NO_VALID, '0, ERASED_WORD, 1'b0};
            end else begin
              idx_nxt  = idx_r + 1'b1;
              base_nxt = base_r + SLOT_STEP;
            end
          end
        endcase
      end

      S_RWORD: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_rsp_nxt   = rsp_t'{ST_OK, SLOT_W'(idx_r), wrd_rdata, 1'b0};
      end

      S_WSCAN: begin
        if (hdr_rd.st == SLOT_FREE) begin
          // First free slot becomes the new valid record.
          hdr_we        = 1'b1;
          hdr_wdata     = hdr_t'{st: SLOT_VALID, fill: '0};
          open_slot_nxt = idx_r;
          open_base_nxt = base_r;
          erased_nxt    = 1'b0;
          state_nxt     = S_OPEN;
        end else begin
          if (hdr_rd.st == SLOT_VALID) begin
            hdr_we    = 1'b1;
            hdr_wdata = hdr_t'{st: SLOT_INVALID, fill: hdr_rd.fill};
          end
          if (last_slot) begin
            // Area full: sweep every header back to free, slot 0 to valid.
            state_nxt = S_ERASE;
            idx_nxt   = '0;
          end else begin
            idx_nxt  = idx_r + 1'b1;
            base_nxt = base_r + SLOT_STEP;
          end
        end
      end

      S_ERASE: begin
        hdr_we = 1'b1;
        if (idx_r == '0) begin
          hdr_wdata = hdr_t'{st: SLOT_VALID, fill: '0};
        end
        if (last_slot) begin
          open_slot_nxt = '0;
          open_base_nxt = '0;
          erased_nxt    = 1'b1;
          state_nxt     = S_OPEN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_OPEN: begin
        open_pos_nxt  = '0;
        open_len_nxt  = req_r.byte_count[FILL_W:1];
        rec_open_nxt  = (req_r.byte_count[FILL_W:1] != '0);
        st_pos        = '0;
        do_store      = (req_r.byte_count[FILL_W:1] != '0);
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_rsp_nxt   = rsp_t'{ST_OK, SLOT_W'(open_slot_r), '0, erased_r};
      end

      default: begin
        state_nxt = S_CLEAR;
        idx_nxt   = '0;
      end
    endcase

    if (do_store) begin
      wrd_we       = 1'b1;
      wrd_waddr    = open_base_r + AW'(st_pos);
      wrd_wdata    = store_data;
      hdr_we       = 1'b1;
      hdr_waddr    = open_slot_r;
      hdr_wdata    = hdr_t'{st: SLOT_VALID, fill: st_pos_inc};
      open_pos_nxt = st_pos_inc;
      if (st_pos_inc >= open_len_nxt) begin
        rec_open_nxt = 1'b0;
      end
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

// ----- sv/wlrs_ram.sv -----
// ----------------------------------------------------------------------------
// wlrs_ram: generic simple dual port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module wlrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/wlrs_checker.sv -----
// ----------------------------------------------------------------------------
// wlrs_checker: port level checks of the wear leveled record store
// Watches the transaction ports and is bound to the top level.
// ----------------------------------------------------------------------------
module wlrs_checker #(
  parameter int WORDS_PER_SLOT = wlrs_pkg::WORDS_PER_SLOT_DEF
) (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input wlrs_pkg::req_t in_req,
  input logic           out_valid,
  input wlrs_pkg::rsp_t out_rsp
);

  import wlrs_pkg::*;

  localparam logic [7:0] LEN_MAX = 8'(2 * WORDS_PER_SLOT);

  // A failed transaction never names a slot.
  a_err_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.status != ST_OK |-> out_rsp.slot == '0)
    else $error("error result names a slot");

  // A read that finds no valid record returns erased data.
  a_no_valid_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.status == ST_NO_VALID |-> out_rsp.read_data == ERASED_WORD)
    else $error("no valid record but data not erased");

  // An oversized record is rejected in the very next cycle.
  a_len_err_now: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req.req_type && in_req.first && in_req.byte_count > LEN_MAX
    |=> out_valid && out_rsp.status == ST_LEN_ERR)
    else $error("length error not reported at once");

  // Outside reset the block only turns busy by accepting a transaction.
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted transaction");

endmodule

bind wear_leveled_record_store wlrs_checker #(.WORDS_PER_SLOT(WORDS_PER_SLOT)) u_wlrs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);

// ----- sim/wlrs_checker.sv -----
// ----------------------------------------------------------------------------
// wlrs_record_checker: scoreboard for the wear leveled record store
// Keeps its own model of the slot headers and halfwords. It predicts one
// response per accepted transaction and compares every out_valid response
// with the oldest prediction.
// ----------------------------------------------------------------------------
module wlrs_record_checker
  import wlrs_pkg::*;
#(
  parameter int NUM_SLOTS      = NUM_SLOTS_DEF,
  parameter int WORDS_PER_SLOT = WORDS_PER_SLOT_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  req_t in_req,
  input  logic out_valid,
  input  rsp_t out_rsp,
  output int   mismatches,
  output int   pending
);

  slot_state_t       hdr_state [NUM_SLOTS];
  logic [FILL_W-1:0] hdr_fill  [NUM_SLOTS];
  logic [DATA_W-1:0] halfwords [NUM_SLOTS*WORDS_PER_SLOT];
  logic [SLOT_W-1:0] cur_slot;
  int unsigned       cur_pos;
  int unsigned       cur_len;
  logic              cur_open;

  rsp_t pending_rsp_q[$];
  int   fail_count;

  initial begin
    fail_count = 0;
  end

  function automatic void clear_headers();
    for (int k = 0; k < NUM_SLOTS; k++) begin
      hdr_state[k] = SLOT_FREE;
      hdr_fill[k]  = '0;
    end
  endfunction

  // Append one halfword to the open record and close it once it is full.
  function automatic void append_halfword(logic [DATA_W-1:0] d);
    if (cur_pos < WORDS_PER_SLOT) begin
      halfwords[cur_slot*WORDS_PER_SLOT + cur_pos] = d;
      hdr_fill[cur_slot] = FILL_W'(cur_pos + 1);
    end
    cur_pos++;
    if (cur_pos >= cur_len) cur_open = 1'b0;
  endfunction

  // Applies one transaction to the model and returns the response it earns.
  function automatic rsp_t next_response(req_t r);
    rsp_t res;
    int   hit;
    bit   found;
    res   = '0;
    hit   = -1;
    found = 1'b0;
    if (!r.req_type) begin
      // The lowest valid slot wins; walk downward so it is the last hit.
      for (int k = NUM_SLOTS - 1; k >= 0; k--)
        if (hdr_state[k] == SLOT_VALID) hit = k;
      if (hit < 0) begin
        res.status    = ST_NO_VALID;
        res.read_data = ERASED_WORD;
      end else begin
        res.status    = ST_OK;
        res.slot      = SLOT_W'(hit);
        res.read_data = ERASED_WORD;
        if (r.word_index < WORDS_PER_SLOT && r.word_index < hdr_fill[hit])
          res.read_data = halfwords[hit*WORDS_PER_SLOT + r.word_index];
      end
    end else if (r.first) begin
      if (r.byte_count > 2*WORDS_PER_SLOT) begin
        cur_open   = 1'b0;
        res.status = ST_LEN_ERR;
      end else begin
        // Retire every valid slot up to the first free one, then claim it.
        for (int k = 0; k < NUM_SLOTS; k++) begin
          if (!found) begin
            if (hdr_state[k] == SLOT_VALID) begin
              hdr_state[k] = SLOT_INVALID;
            end else if (hdr_state[k] == SLOT_FREE) begin
              hdr_state[k] = SLOT_VALID;
              hdr_fill[k]  = '0;
              cur_slot     = SLOT_W'(k);
              found        = 1'b1;
            end
          end
        end
        if (!found) begin
          clear_headers();
          hdr_state[0] = SLOT_VALID;
          cur_slot     = '0;
        end
        cur_pos  = 0;
        cur_len  = r.byte_count >> 1;
        cur_open = (cur_len > 0);
        if (cur_open) append_halfword(r.data);
        res.status     = ST_OK;
        res.slot       = cur_slot;
        res.erased_all = !found;
      end
    end else if (!cur_open) begin
      res.status = ST_IGNORED;
    end else begin
      append_halfword(r.data);
      res.status = ST_OK;
      res.slot   = cur_slot;
    end
    return res;
  endfunction

  function automatic void note_mismatch(string field, int unsigned want, int unsigned got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endfunction

  always @(posedge clk) begin : watch
    rsp_t want;
    if (!rst_n) begin
      clear_headers();
      cur_slot = '0;
      cur_pos  = 0;
      cur_len  = 0;
      cur_open = 1'b0;
      pending_rsp_q.delete();
    end else begin
      // Compare before pushing: a transaction accepted on this edge cannot
      // already have its response on the ports.
      if (out_valid) begin
        if (pending_rsp_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected response, expected none, actual %h",
                   $time, out_rsp);
        end else begin
          want = pending_rsp_q.pop_front();
          if (out_rsp.status !== want.status)
            note_mismatch("status", want.status, out_rsp.status);
          if (out_rsp.slot !== want.slot)
            note_mismatch("slot", want.slot, out_rsp.slot);
          if (out_rsp.read_data !== want.read_data)
            note_mismatch("read_data", want.read_data, out_rsp.read_data);
          if (out_rsp.erased_all !== want.erased_all)
            note_mismatch("erased_all", want.erased_all, out_rsp.erased_all);
        end
      end
      if (start && !busy) pending_rsp_q.push_back(next_response(in_req));
    end
    mismatches <= fail_count;
    pending    <= pending_rsp_q.size();
  end

endmodule

// ----- sim/wear_leveled_record_store_tb.sv -----
// ----------------------------------------------------------------------------
// wear_leveled_record_store_tb: top level testbench of the record store
// Drives directed and random read and write transactions in bursts, while a
// separate checker predicts and compares every response.
// ----------------------------------------------------------------------------
module wear_leveled_record_store_tb;
  import wlrs_pkg::*;

  localparam int NUM_SLOTS      = NUM_SLOTS_DEF;
  localparam int WORDS_PER_SLOT = WORDS_PER_SLOT_DEF;
  localparam int TARGET_ITEMS   = 1350;
  // Worst case of one transaction is a full scan plus an erase sweep.
  localparam int DRAIN_CYCLES   = 2*NUM_SLOTS + 10;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  req_t in_req;
  logic out_valid;
  rsp_t out_rsp;

  int mismatches;
  int pending;
  int sent;
  int burst_left;

  wear_leveled_record_store #(
    .NUM_SLOTS      (NUM_SLOTS),
    .WORDS_PER_SLOT (WORDS_PER_SLOT)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  wlrs_record_checker #(
    .NUM_SLOTS      (NUM_SLOTS),
    .WORDS_PER_SLOT (WORDS_PER_SLOT)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_rsp    (out_rsp),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop. The slowest legal run is far below this figure, so getting
  // here means the block stopped answering.
  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

  // Drop start while the request bus carries noise, which the block must
  // ignore while start is low; the argument n sets the length of the gap.
  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start  <= 1'b0;
      in_req <= req_t'($urandom);
    end
  endtask

  // Hold off until the checker has seen every outstanding response.
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Present one transaction and hold it until the block takes it. Bursts of
  // random length alternate with random gaps, back-to-back runs and the
  // occasional full drain, so gaps land on every phase of a scan or erase.
  task automatic push_item(req_t r);
    @(negedge clk);
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      case ($urandom_range(0, 9))
        0:       wait_drained();
        1, 2:    begin end
        default: idle_cycles($urandom_range(1, 12));
      endcase
    end
  endtask

  // The three transaction flavors. Fields that a flavor does not use carry
  // random values, so every request bit toggles in every mode.
  task automatic send_read(int idx);
    req_t r;
    r = req_t'($urandom);
    r.req_type   = 1'b0;
    r.word_index = idx[5:0];
    push_item(r);
  endtask

  task automatic send_first(int bc, logic [DATA_W-1:0] d);
    req_t r;
    r = req_t'($urandom);
    r.req_type   = 1'b1;
    r.first      = 1'b1;
    r.byte_count = bc[7:0];
    r.data       = d;
    push_item(r);
  endtask

  task automatic send_data(logic [DATA_W-1:0] d);
    req_t r;
    r = req_t'($urandom);
    r.req_type = 1'b1;
    r.first    = 1'b0;
    r.data     = d;
    push_item(r);
  endtask

  // Mostly indexes near the written length, where the fill boundary sits,
  // and now and then anywhere in the 6-bit range.
  function automatic int pick_index(int len);
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 63);
    return $urandom_range(0, (len + 1 > 63) ? 63 : len + 1);
  endfunction

  initial begin : stimulus
    int pick;
    int sel;
    int bc;
    int len;
    int n;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_req     = '0;
    sent       = 0;
    burst_left = 4;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. The block is in its header clearing pass now; the
    // first transaction simply waits for busy to drop.
    send_read(0);                     // nothing valid yet
    send_data(16'hFFFF);              // write with no record open
    send_first(125, 16'h1111);        // one byte over the limit
    send_first(255, 16'h2222);        // largest byte count
    send_first(0, 16'h1234);          // empty record in slot 0
    send_read(0);                     // empty record reads as erased
    send_first(5, 16'h0000);          // odd byte count drops the last byte
    send_data(16'hFFFF);              // completes the two-halfword record
    send_data(16'h5A5A);              // record already closed
    send_read(0);
    send_read(1);
    send_read(2);                     // just past the fill
    send_first(124, 16'hA5C3);        // largest legal record
    send_data(16'h0F0F);
    send_data(16'hF0F0);
    send_first(4, 16'h8001);          // new record while one is open
    send_first(200, 16'h3333);        // length error closes the open record
    send_data(16'h4444);              // so this write is ignored
    send_read(63);                    // beyond the slot size
    send_read(0);
    send_first(1, 16'h7777);          // one byte rounds down to an empty record
    send_read(0);
    wait_drained();

    // Random part. Most draws are complete records with random content,
    // sometimes interleaved with reads or cut short by the next allocation.
    // Short records dominate so that the slot row wraps and gets erased a
    // few times over the run.
    while (sent < TARGET_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        sel = $urandom_range(0, 49);
        if (sel < 45)      bc = $urandom_range(0, 21);
        else if (sel < 49) bc = $urandom_range(0, 2*WORDS_PER_SLOT);
        else               bc = 2*WORDS_PER_SLOT - 1 + $urandom_range(0, 1);
        len = bc / 2;
        n   = len;
        if (len > 1 && $urandom_range(0, 9) == 0) n = $urandom_range(1, len - 1);
        send_first(bc, DATA_W'($urandom));
        for (int k = 1; k < n; k++) begin
          if ($urandom_range(0, 6) == 0) send_read(pick_index(len));
          send_data(DATA_W'($urandom));
        end
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) send_read(pick_index(WORDS_PER_SLOT));
      end else if (pick < 92) begin
        send_first($urandom_range(2*WORDS_PER_SLOT + 1, 255), DATA_W'($urandom));
      end else begin
        send_data(DATA_W'($urandom));
      end
    end

    // Let the last responses arrive, then watch a while longer for any
    // response that nothing asked for.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
